// ----- hdl/mpc_pkg.sv -----
// Shared types, codes and constants for the motion phase classifier.
// Used by every module under hdl but mpc_queue; depends on nothing else.
package mpc_pkg;

   // Field widths.
   localparam int SPEED_W  = 16;
   localparam int ABS_W    = SPEED_W + 1;
   localparam int LIMIT_W  = 15;
   localparam int HOLD_W   = 24;
   localparam int TIME_W   = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Defaults for the top-level parameters.
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam logic [HOLD_W-1:0] STATIONARY_HOLD_DEFAULT = 24'd200000;

   // Register reset values.
   localparam logic [LIMIT_W-1:0] STAT_LIN_RESET   = 15'd20;
   localparam logic [LIMIT_W-1:0] STAT_ANG_RESET   = 15'd20;
   localparam logic [LIMIT_W-1:0] TURN_ENTER_RESET = 15'd200;
   localparam logic [LIMIT_W-1:0] TURN_EXIT_RESET  = 15'd100;
   localparam logic [LIMIT_W-1:0] ARC_ENTER_RESET  = 15'd100;
   localparam logic [LIMIT_W-1:0] ARC_EXIT_RESET   = 15'd50;
   localparam logic [HOLD_W-1:0]  ENTER_HOLD_RESET = 24'd100000;
   localparam logic [HOLD_W-1:0]  EXIT_HOLD_RESET  = 24'd200000;

   // Phase codes as they appear on the result port.
   typedef enum logic [1:0] {
      PH_STRAIGHT   = 2'd0,
      PH_STATIONARY = 2'd1,
      PH_TURNING    = 2'd2,
      PH_ARC        = 2'd3
   } phase_type;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STAT_LIN   = 3'd0,
      REG_STAT_ANG   = 3'd1,
      REG_TURN_ENTER = 3'd2,
      REG_TURN_EXIT  = 3'd3,
      REG_ARC_ENTER  = 3'd4,
      REG_ARC_EXIT   = 3'd5,
      REG_ENTER_HOLD = 3'd6,
      REG_EXIT_HOLD  = 3'd7
   } csr_index_type;

   // A request after the front end has compared it against all thresholds.
   typedef struct packed {
      logic              stationary;
      logic              turn_enter_hit;
      logic              turn_exit_hit;
      logic              arc_enter_hit;
      logic              arc_exit_hit;
      logic              discard;
      logic [TIME_W-1:0] sample_time;
   } sample_flags_type;

   // Hold times that the back end needs from the register file.
   typedef struct packed {
      logic [HOLD_W-1:0] enter_hold;
      logic [HOLD_W-1:0] exit_hold;
   } hold_cfg_type;

   // One result as it waits in the output queue.
   typedef struct packed {
      phase_type phase;
      logic      pending;
   } result_type;

endpackage

// ----- hdl/mpc_queue.sv -----
// Small first-in first-out queue of registers with a type parameter.
// Used between the front and back ends and on the result side; no package needed.
module mpc_queue #(
   parameter type item_type = logic,
   parameter int  DEPTH     = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_data,
   output logic     full,
   input  logic     pop,
   output item_type pop_data,
   output logic     empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   item_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // Pointer and count update, wrapping at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mpc_front.sv -----
// Front end: configuration registers and threshold compares for each request.
// Depends on mpc_pkg.
module mpc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [mpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0]      csr_data,
   input  logic signed [mpc_pkg::SPEED_W-1:0]  linear_speed,
   input  logic signed [mpc_pkg::SPEED_W-1:0]  angular_rate,
   input  logic [mpc_pkg::TIME_W-1:0]          sample_time,
   input  logic                                discard,
   output mpc_pkg::sample_flags_type           flags,
   output mpc_pkg::hold_cfg_type               hold_cfg
);
   import mpc_pkg::*;

   logic [LIMIT_W-1:0] stat_lin_ff, stat_ang_ff;
   logic [LIMIT_W-1:0] turn_enter_ff, turn_exit_ff;
   logic [LIMIT_W-1:0] arc_enter_ff, arc_exit_ff;
   logic [HOLD_W-1:0]  enter_hold_ff, exit_hold_ff;
   logic [ABS_W-1:0]   lin_ext, ang_ext, lin_abs, ang_abs;

   // Register writes; values are truncated to the register width.
   always_ff @(posedge clock) begin
      if (reset) begin
         stat_lin_ff   <= STAT_LIN_RESET;
         stat_ang_ff   <= STAT_ANG_RESET;
         turn_enter_ff <= TURN_ENTER_RESET;
         turn_exit_ff  <= TURN_EXIT_RESET;
         arc_enter_ff  <= ARC_ENTER_RESET;
         arc_exit_ff   <= ARC_EXIT_RESET;
         enter_hold_ff <= ENTER_HOLD_RESET;
         exit_hold_ff  <= EXIT_HOLD_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            REG_STAT_LIN:   stat_lin_ff   <= csr_data[LIMIT_W-1:0];
            REG_STAT_ANG:   stat_ang_ff   <= csr_data[LIMIT_W-1:0];
            REG_TURN_ENTER: turn_enter_ff <= csr_data[LIMIT_W-1:0];
            REG_TURN_EXIT:  turn_exit_ff  <= csr_data[LIMIT_W-1:0];
            REG_ARC_ENTER:  arc_enter_ff  <= csr_data[LIMIT_W-1:0];
            REG_ARC_EXIT:   arc_exit_ff   <= csr_data[LIMIT_W-1:0];
            REG_ENTER_HOLD: enter_hold_ff <= csr_data[HOLD_W-1:0];
            REG_EXIT_HOLD:  exit_hold_ff  <= csr_data[HOLD_W-1:0];
         endcase
      end
   end

   // Magnitudes in one extra bit so the most negative value stays exact.
   assign lin_ext = {linear_speed[SPEED_W-1], linear_speed};
   assign ang_ext = {angular_rate[SPEED_W-1], angular_rate};
   assign lin_abs = linear_speed[SPEED_W-1] ? (ABS_W'(0) - lin_ext) : lin_ext;
   assign ang_abs = angular_rate[SPEED_W-1] ? (ABS_W'(0) - ang_ext) : ang_ext;

   // Every compare the classifier could need; the back end picks by phase.
   always_comb begin
      flags.stationary     = (lin_abs <= ABS_W'(stat_lin_ff)) &&
                             (ang_abs <= ABS_W'(stat_ang_ff));
      flags.turn_enter_hit = (ang_abs >= ABS_W'(turn_enter_ff));
      flags.turn_exit_hit  = (ang_abs >= ABS_W'(turn_exit_ff));
      flags.arc_enter_hit  = (lin_abs >= ABS_W'(arc_enter_ff));
      flags.arc_exit_hit   = (lin_abs >= ABS_W'(arc_exit_ff));
      flags.discard        = discard;
      flags.sample_time    = sample_time;
   end

   assign hold_cfg.enter_hold = enter_hold_ff;
   assign hold_cfg.exit_hold  = exit_hold_ff;

endmodule

// ----- hdl/mpc_back.sv -----
// Back end: phase state, candidate timing and hold decisions, one request a cycle
// while the result queue has room. Depends on mpc_pkg.
module mpc_back #(
   parameter logic [mpc_pkg::HOLD_W-1:0] STATIONARY_HOLD_US = mpc_pkg::STATIONARY_HOLD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mpc_pkg::sample_flags_type  item,
   input  logic                       item_valid,
   output logic                       item_take,
   input  mpc_pkg::hold_cfg_type      hold_cfg,
   input  logic                       result_full,
   output logic                       result_push,
   output mpc_pkg::result_type        result
);
   import mpc_pkg::*;

   phase_type         phase_ff, phase_in;
   logic              pend_valid_ff, pend_valid_in;
   phase_type         pend_target_ff, pend_target_in;
   logic [TIME_W-1:0] pend_start_ff, pend_start_in;
   logic [TIME_W:0]   diff;
   logic              stale, in_band, turn_hit, arc_hit, held;
   phase_type         target;
   logic [HOLD_W-1:0] hold;

   assign item_take   = item_valid && !result_full;
   assign result_push = item_take;

   // Elapsed time since the candidate start; a borrow or zero marks a stale stamp.
   assign diff  = {1'b0, item.sample_time} - {1'b0, pend_start_ff};
   assign stale = pend_valid_ff && (diff[TIME_W] || (diff[TIME_W-1:0] == '0));

   // Class of this request, with hysteresis picked by the current phase.
   always_comb begin
      in_band  = (phase_ff == PH_TURNING) || (phase_ff == PH_ARC);
      turn_hit = in_band ? item.turn_exit_hit : item.turn_enter_hit;
      arc_hit  = (phase_ff == PH_ARC) ? item.arc_exit_hit : item.arc_enter_hit;
      if (item.stationary) begin
         target = PH_STATIONARY;
      end else if (turn_hit) begin
         target = arc_hit ? PH_ARC : PH_TURNING;
      end else begin
         target = PH_STRAIGHT;
      end
   end

   // Hold time that the candidate must last.
   always_comb begin
      unique case (target)
         PH_STATIONARY: hold = STATIONARY_HOLD_US;
         PH_STRAIGHT:   hold = hold_cfg.exit_hold;
         PH_TURNING,
         PH_ARC:        hold = hold_cfg.enter_hold;
      endcase
      held = (diff[TIME_W-1:0] >= TIME_W'(hold));
   end

   // State update for one request.
   always_comb begin
      phase_in       = phase_ff;
      pend_valid_in  = pend_valid_ff;
      pend_target_in = pend_target_ff;
      pend_start_in  = pend_start_ff;
      if (item_take) begin
         priority if (item.discard || stale) begin
            phase_in       = PH_STRAIGHT;
            pend_valid_in  = 1'b0;
            pend_target_in = PH_STRAIGHT;
            pend_start_in  = '0;
         end else if (target == phase_ff) begin
            pend_valid_in = 1'b0;
         end else if (phase_ff == PH_STATIONARY) begin
            phase_in      = target;
            pend_valid_in = 1'b0;
         end else if (!pend_valid_ff || (pend_target_ff != target)) begin
            pend_valid_in  = 1'b1;
            pend_target_in = target;
            pend_start_in  = item.sample_time;
         end else if (held) begin
            phase_in      = target;
            pend_valid_in = 1'b0;
         end
      end
   end

   assign result.phase   = phase_in;
   assign result.pending = pend_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_STRAIGHT;
         pend_valid_ff  <= 1'b0;
         pend_target_ff <= PH_STRAIGHT;
         pend_start_ff  <= '0;
      end else begin
         phase_ff       <= phase_in;
         pend_valid_ff  <= pend_valid_in;
         pend_target_ff <= pend_target_in;
         pend_start_ff  <= pend_start_in;
      end
   end

   // A discarded request always reports straight with nothing pending.
   a_discard_clears: assert property (@(posedge clock) disable iff (reset)
      (item_take && item.discard) |-> (result.phase == PH_STRAIGHT && !result.pending))
      else $error("discard did not clear the phase");

   // The phase moves only when a request is processed.
   a_phase_holds: assert property (@(posedge clock) disable iff (reset)
      !item_take |=> $stable(phase_ff))
      else $error("phase changed without a request");

   // Leaving stationary never starts a timed candidate.
   a_stationary_exit: assert property (@(posedge clock) disable iff (reset)
      (item_take && phase_ff == PH_STATIONARY) |=> !pend_valid_ff)
      else $error("candidate pending after leaving stationary");

   // A pending candidate always differs from the current phase.
   a_target_differs: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (pend_target_ff != phase_ff))
      else $error("pending target equals current phase");

endmodule

// ----- hdl/motion_phase_classifier.sv -----
// Motion phase classifier: each request carries linear speed (mm/s), angular
// rate (mrad/s), a timestamp (us) and a discard flag, and yields exactly one
// response with the phase after that sample (0 straight, 1 stationary,
// 2 turning, 3 arc) and whether a phase change is being timed. Requests are
// taken one per clock cycle, sustained, as long as responses are popped;
// throughput is set by the back end, which updates the phase state once per
// cycle while the output queue has room. Up to QUEUE_DEPTH requests sit
// between the front and back ends and up to QUEUE_DEPTH responses wait on
// the output side. The eight registers (indexes 0 to 7) reset to 20, 20,
// 200, 100, 100, 50, 100000 and 200000, csr_ready is always high, and they
// should be written only with no request in flight. Depends on mpc_pkg,
// mpc_queue, mpc_front and mpc_back.
module motion_phase_classifier #(
   parameter int                          QUEUE_DEPTH = mpc_pkg::QUEUE_DEPTH_DEFAULT,
   parameter logic [mpc_pkg::HOLD_W-1:0] STATIONARY_HOLD_US =
      mpc_pkg::STATIONARY_HOLD_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [mpc_pkg::SPEED_W-1:0]  req_linear_speed,
   input  logic signed [mpc_pkg::SPEED_W-1:0]  req_angular_rate,
   input  logic [mpc_pkg::TIME_W-1:0]          req_sample_time,
   input  logic                                req_discard,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic [1:0]                          rsp_motion_phase,
   output logic                                rsp_switch_pending,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [mpc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mpc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import mpc_pkg::*;

   sample_flags_type front_flags, back_item;
   hold_cfg_type     hold_cfg;
   logic             mid_empty, back_take;
   logic             out_full, out_push;
   result_type       back_result, out_result;

   assign csr_ready = 1'b1;

   // Threshold compares and register file.
   mpc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .linear_speed (req_linear_speed),
      .angular_rate (req_angular_rate),
      .sample_time  (req_sample_time),
      .discard      (req_discard),
      .flags        (front_flags),
      .hold_cfg     (hold_cfg)
   );

   // Queue of classified requests between the two ends.
   mpc_queue #(
      .item_type (sample_flags_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_flags),
      .full      (req_full),
      .pop       (back_take),
      .pop_data  (back_item),
      .empty     (mid_empty)
   );

   // Phase state and hold timing.
   mpc_back #(
      .STATIONARY_HOLD_US (STATIONARY_HOLD_US)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .item        (back_item),
      .item_valid  (!mid_empty),
      .item_take   (back_take),
      .hold_cfg    (hold_cfg),
      .result_full (out_full),
      .result_push (out_push),
      .result      (back_result)
   );

   // Responses waiting to be popped.
   mpc_queue #(
      .item_type (result_type),
      .DEPTH     (QUEUE_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (back_result),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   assign rsp_motion_phase   = out_result.phase;
   assign rsp_switch_pending = out_result.pending;

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for motion_phase_classifier: requests flow through a queue-driven
// driver, and a clocked monitor compares every response with an in-house phase predictor.
// Depends on mpc_pkg and the motion_phase_classifier RTL only.
`timescale 1ns / 1ps

module tb;
   import mpc_pkg::*;

   localparam logic [HOLD_W-1:0] STAT_HOLD = STATIONARY_HOLD_DEFAULT;

   // One odometry request as the stimulus queues it.
   typedef struct {
      logic signed [SPEED_W-1:0] lin;
      logic signed [SPEED_W-1:0] ang;
      logic [TIME_W-1:0]         stamp;
      logic                      disc;
   } odo_sample_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic signed [SPEED_W-1:0]  req_linear_speed = '0;
   logic signed [SPEED_W-1:0]  req_angular_rate = '0;
   logic [TIME_W-1:0]          req_sample_time = '0;
   logic                       req_discard = 1'b0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic [1:0]                 rsp_motion_phase;
   logic                       rsp_switch_pending;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   odo_sample_type samples_to_send[$];
   result_type  expected_phases[$];
   int          mismatches = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic [TIME_W-1:0] stamp_cursor = '0;
   result_type  want;

   // Predictor copy of the register file.
   logic [LIMIT_W-1:0] stat_lin   = STAT_LIN_RESET;
   logic [LIMIT_W-1:0] stat_ang   = STAT_ANG_RESET;
   logic [LIMIT_W-1:0] turn_enter = TURN_ENTER_RESET;
   logic [LIMIT_W-1:0] turn_exit  = TURN_EXIT_RESET;
   logic [LIMIT_W-1:0] arc_enter  = ARC_ENTER_RESET;
   logic [LIMIT_W-1:0] arc_exit   = ARC_EXIT_RESET;
   logic [HOLD_W-1:0]  enter_hold = ENTER_HOLD_RESET;
   logic [HOLD_W-1:0]  exit_hold  = EXIT_HOLD_RESET;

   // Predictor copy of the phase state.
   phase_type         cur_phase   = PH_STRAIGHT;
   logic              cand_valid  = 1'b0;
   phase_type         cand_target = PH_STRAIGHT;
   logic [TIME_W-1:0] cand_start  = '0;

   motion_phase_classifier #(
      .STATIONARY_HOLD_US(STAT_HOLD)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_linear_speed   (req_linear_speed),
      .req_angular_rate   (req_angular_rate),
      .req_sample_time    (req_sample_time),
      .req_discard        (req_discard),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_motion_phase   (rsp_motion_phase),
      .rsp_switch_pending (rsp_switch_pending),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #1_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // Magnitude of a signed speed; the most negative value maps to 32768.
   function automatic logic [ABS_W-1:0] magnitude(input logic signed [SPEED_W-1:0] v);
      int x;
      x = v;
      if (x < 0) begin
         x = -x;
      end
      return x[ABS_W-1:0];
   endfunction

   // Applies one request to the predicted state and returns the response it yields.
   function automatic result_type predict_phase(input logic signed [SPEED_W-1:0] lin,
                                                input logic signed [SPEED_W-1:0] ang,
                                                input logic [TIME_W-1:0] stamp,
                                                input logic disc);
      logic [ABS_W-1:0]   lin_mag;
      logic [ABS_W-1:0]   ang_mag;
      logic [LIMIT_W-1:0] rate_thr;
      logic [LIMIT_W-1:0] speed_thr;
      logic [HOLD_W-1:0]  hold;
      phase_type          target;
      result_type         res;
      lin_mag = magnitude(lin);
      ang_mag = magnitude(ang);
      if (disc || (cand_valid && stamp <= cand_start)) begin
         // A discard or a timestamp that fails to move past the candidate start.
         cur_phase   = PH_STRAIGHT;
         cand_valid  = 1'b0;
         cand_target = PH_STRAIGHT;
         cand_start  = '0;
      end else begin
         // Classify, using the exit thresholds while already inside a band.
         if (lin_mag <= stat_lin && ang_mag <= stat_ang) begin
            target = PH_STATIONARY;
         end else begin
            rate_thr  = (cur_phase == PH_TURNING || cur_phase == PH_ARC) ? turn_exit : turn_enter;
            speed_thr = (cur_phase == PH_ARC) ? arc_exit : arc_enter;
            if (ang_mag < rate_thr) begin
               target = PH_STRAIGHT;
            end else begin
               target = (lin_mag >= speed_thr) ? PH_ARC : PH_TURNING;
            end
         end
         hold = (target == PH_STATIONARY) ? STAT_HOLD :
                (target == PH_STRAIGHT) ? exit_hold : enter_hold;
         // Decide whether the candidate is dropped, restarted or adopted.
         if (target == cur_phase) begin
            cand_valid = 1'b0;
         end else if (cur_phase == PH_STATIONARY) begin
            cur_phase  = target;
            cand_valid = 1'b0;
         end else if (!cand_valid || cand_target != target) begin
            cand_valid  = 1'b1;
            cand_target = target;
            cand_start  = stamp;
         end else if (stamp - cand_start >= TIME_W'(hold)) begin
            cur_phase  = target;
            cand_valid = 1'b0;
         end
      end
      res.phase   = cur_phase;
      res.pending = cand_valid;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int wanted);
      $display("%0t ns: mismatch on %s, got %0d, expected %0d", $time, what, got, wanted);
      mismatches++;
   endtask

   // Driver: presents the oldest queued request unless the sender idles this cycle.
   always @(negedge clock) begin
      if (!reset && samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
         req_push         <= 1'b1;
         req_linear_speed <= samples_to_send[0].lin;
         req_angular_rate <= samples_to_send[0].ang;
         req_sample_time  <= samples_to_send[0].stamp;
         req_discard      <= samples_to_send[0].disc;
      end else begin
         req_push <= 1'b0;
      end
   end

   // Response side stalls at random.
   always @(negedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Monitor: checks popped responses, predicts accepted requests, tracks register writes.
   always @(posedge clock) begin
      if (!reset) begin
         if (!rsp_empty && rsp_pop) begin
            if (expected_phases.size() == 0) begin
               report_mismatch("response with no request outstanding", rsp_motion_phase, -1);
            end else begin
               want = expected_phases.pop_front();
               if (rsp_motion_phase !== want.phase) begin
                  report_mismatch("motion_phase", rsp_motion_phase, want.phase);
               end
               if (rsp_switch_pending !== want.pending) begin
                  report_mismatch("switch_pending", rsp_switch_pending, want.pending);
               end
            end
         end
         if (req_push && !req_full) begin
            expected_phases.push_back(predict_phase(req_linear_speed, req_angular_rate,
                                                    req_sample_time, req_discard));
            void'(samples_to_send.pop_front());
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_STAT_LIN:   stat_lin   = csr_data[LIMIT_W-1:0];
               REG_STAT_ANG:   stat_ang   = csr_data[LIMIT_W-1:0];
               REG_TURN_ENTER: turn_enter = csr_data[LIMIT_W-1:0];
               REG_TURN_EXIT:  turn_exit  = csr_data[LIMIT_W-1:0];
               REG_ARC_ENTER:  arc_enter  = csr_data[LIMIT_W-1:0];
               REG_ARC_EXIT:   arc_exit   = csr_data[LIMIT_W-1:0];
               REG_ENTER_HOLD: enter_hold = csr_data[HOLD_W-1:0];
               REG_EXIT_HOLD:  exit_hold  = csr_data[HOLD_W-1:0];
               default: ;
            endcase
         end
      end
   end

   function automatic void add_sample(input logic signed [SPEED_W-1:0] lin,
                                      input logic signed [SPEED_W-1:0] ang,
                                      input logic [TIME_W-1:0] stamp, input logic disc);
      odo_sample_type s;
      s.lin   = lin;
      s.ang   = ang;
      s.stamp = stamp;
      s.disc  = disc;
      samples_to_send.push_back(s);
   endfunction

   // Magnitude near one of the current thresholds, or an extreme, or anything.
   function automatic int level_value(input int sel);
      case (sel)
         0: return 0;
         1: return stat_lin;
         2: return stat_ang;
         3: return turn_enter;
         4: return turn_exit;
         5: return arc_enter;
         6: return arc_exit;
         7: return 32768;
         default: return int'($urandom_range(32768));
      endcase
   endfunction

   // A signed speed within a few counts of the given magnitude, either sign.
   function automatic logic signed [SPEED_W-1:0] jittered(input int base);
      int mag;
      mag = base + int'($urandom_range(6)) - 3;
      if (mag < 0) begin
         mag = 0;
      end
      if (mag > 32768) begin
         mag = 32768;
      end
      if ($urandom_range(1) == 1) begin
         mag = -mag;
      end
      if (mag == 32768) begin
         mag = -32768;
      end
      return SPEED_W'(mag);
   endfunction

   // Runs of similar samples with advancing time, plus some discards and stale stamps.
   function automatic void queue_random_chunk(input int count);
      int unsigned hold_max;
      int unsigned step_cap;
      int          lin_sel;
      int          ang_sel;
      int          run_left;
      logic [TIME_W-1:0] stamp;
      hold_max = STAT_HOLD;
      if (enter_hold > hold_max) begin
         hold_max = enter_hold;
      end
      if (exit_hold > hold_max) begin
         hold_max = exit_hold;
      end
      step_cap = hold_max / 3 + 1;
      run_left = 0;
      lin_sel  = 0;
      ang_sel  = 0;
      for (int n = 0; n < count; n++) begin
         if (run_left == 0) begin
            lin_sel  = $urandom_range(8);
            ang_sel  = $urandom_range(8);
            run_left = $urandom_range(1, 10);
         end
         run_left--;
         if ($urandom_range(99) < 4) begin
            stamp = stamp_cursor - $urandom_range(step_cap);
         end else begin
            stamp_cursor = stamp_cursor + $urandom_range(step_cap);
            stamp = stamp_cursor;
         end
         add_sample(jittered(level_value(lin_sel)), jittered(level_value(ang_sel)), stamp,
                    $urandom_range(99) < 4);
      end
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Limit registers get random junk above bit 14 to show that it is ignored.
   task automatic program_regs(input int unsigned s_lin, input int unsigned s_ang,
                               input int unsigned t_in, input int unsigned t_out,
                               input int unsigned a_in, input int unsigned a_out,
                               input int unsigned h_in, input int unsigned h_out);
      write_reg(REG_STAT_LIN,   {9'($urandom), s_lin[LIMIT_W-1:0]});
      write_reg(REG_STAT_ANG,   {9'($urandom), s_ang[LIMIT_W-1:0]});
      write_reg(REG_TURN_ENTER, {9'($urandom), t_in[LIMIT_W-1:0]});
      write_reg(REG_TURN_EXIT,  {9'($urandom), t_out[LIMIT_W-1:0]});
      write_reg(REG_ARC_ENTER,  {9'($urandom), a_in[LIMIT_W-1:0]});
      write_reg(REG_ARC_EXIT,   {9'($urandom), a_out[LIMIT_W-1:0]});
      write_reg(REG_ENTER_HOLD, h_in[HOLD_W-1:0]);
      write_reg(REG_EXIT_HOLD,  h_out[HOLD_W-1:0]);
   endtask

   // The sender stays quiet until every outstanding response has been popped.
   task automatic wait_for_drain;
      do @(negedge clock); while (samples_to_send.size() != 0 || expected_phases.size() != 0);
   endtask

   // Stimulus sequence.
   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 36;
      recv_idle_pct = 77;

      // Directed requests with the reset thresholds.
      add_sample(0, 0, 48'd1000, 1'b0);                  // stationary candidate
      add_sample(16'sh7fff, 0, 48'd2000, 1'b0);          // back to straight drops it
      add_sample(-32768, -32768, 48'd3000, 1'b0);        // most negative is never small
      add_sample(5, -5, 48'd10000, 1'b0);
      add_sample(0, 0, 48'd210000, 1'b0);                // stationary hold met exactly
      add_sample(-32768, 0, 48'd210001, 1'b0);           // stationary is left at once
      add_sample(10, 300, 48'd300000, 1'b0);             // turning candidate
      add_sample(10, -300, 48'd400000, 1'b0);            // enter hold met exactly
      add_sample(80, 150, 48'd405000, 1'b0);             // exit rate keeps turning
      add_sample(-120, 150, 48'd410000, 1'b0);           // arc candidate
      add_sample(120, 150, 48'd510000, 1'b0);            // arc adopted
      add_sample(60, -120, 48'd520000, 1'b0);            // exit speed keeps arc
      add_sample(500, 0, 48'd600000, 1'b0);              // straight candidate
      add_sample(500, 0, 48'd600000, 1'b0);              // same stamp clears state
      add_sample(0, 0, 48'd700000, 1'b0);
      add_sample(500, 300, 48'd750000, 1'b0);            // candidate changes, timer restarts
      add_sample(500, 300, 48'd700000, 1'b0);            // older stamp clears state
      add_sample(-1, 1, 48'hffff_ffff_ffff, 1'b1);       // discard
      add_sample(16'sh5555, 16'sh2aaa, 48'h0, 1'b0);
      add_sample(16'sh2aaa, 16'sh5555, 48'haaaa_aaaa_aaaa, 1'b0);
      add_sample(-21846, -10923, 48'h5555_5555_5555, 1'b0);
      add_sample(0, 0, 48'hffff_ffff_fffe, 1'b0);
      add_sample(0, 0, 48'hffff_ffff_ffff, 1'b0);
      wait_for_drain;

      // Random chunks, each under a register setting (chunks 0 and 6 share one) and one of three idling patterns.
      for (int chunk = 0; chunk < 9; chunk++) begin
         case (chunk)
            0: program_regs(20, 20, 200, 100, 100, 50, 100000, 200000);
            1: program_regs(5, 5, 60, 30, 40, 20, 1000, 2000);
            2: program_regs(0, 0, 0, 0, 0, 0, 0, 0);
            3: program_regs(32767, 32767, 32767, 32767, 32767, 32767, 16777215, 16777215);
            4: program_regs(30, 30, 100, 400, 50, 300, 500, 300);
            5: program_regs(100, 50, 1000, 800, 2000, 1500, 50000, 80000);
            6: program_regs(20, 20, 200, 100, 100, 50, 100000, 200000);
            7: program_regs(0, 32767, 32767, 0, 32767, 0, 0, 16777215);
            default: program_regs(10, 10, 300, 150, 200, 100, 20000, 40000);
         endcase
         @(posedge clock);
         if (chunk == 3) begin
            send_idle_pct = 77;
            recv_idle_pct = 36;
         end else if (chunk == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         stamp_cursor = (chunk % 2 == 1) ? TIME_W'({$urandom, $urandom})
                                         : TIME_W'($urandom_range(1000));
         queue_random_chunk(150);
         wait_for_drain;
      end

      repeat (20) @(negedge clock);
      if (mismatches == 0 && expected_phases.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
